>>> src/lz77_token_decoder_top_assert.svh
// Assertion macros for the LZ77 token decoder.
// Included by lz77_token_decoder_top.sv; expects signals named clock and reset.
`ifndef LZ77_TOKEN_DECODER_TOP_ASSERT_SVH
`define LZ77_TOKEN_DECODER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LTD_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// An antecedent that must be accompanied by a consequent in the same cycle.
`define LTD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> src/lz77td_pkg.sv
// Shared types and constants for the LZ77 token decoder.
// No dependencies; imported by lz77_token_decoder_top.
package lz77td_pkg;

   // Token bytes of the compressed stream.
   localparam logic [7:0] MARKER_BYTE = 8'h60;
   localparam logic [7:0] ESCAPE_BYTE = 8'hff;

   // Result word layout: four byte lanes and a byte count.
   localparam int OUT_LANES  = 4;
   localparam int COUNT_W    = 3;
   localparam int RSP_DATA_W = 40;

   // Parser phase: what the next code byte means.
   typedef enum logic [1:0] {
      PH_LITERAL = 2'd0,
      PH_MARKER  = 2'd1,
      PH_LENGTH  = 2'd2
   } phase_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

>>> src/lz77_token_decoder_top.sv
// LZ77 token decoder: takes one compressed byte per word and returns decoded bytes, up to
// four per result word. A literal, or an escaped marker, gives one result. A match of
// length L runs the shared history memory once per copied byte, a read state to fetch
// the source byte and a write state to write it back, plus a flush state to hand off
// each result word, which waits while the result side stalls. Marker and distance bytes
// give nothing. The block takes no new word while a match is being copied. The history
// starts out as zeros; no clearing pass is needed.
// Depends on lz77td_pkg and lz77_token_decoder_top_assert.svh.
`include "lz77_token_decoder_top_assert.svh"

module lz77_token_decoder_top
   import lz77td_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Compressed input words.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] code_byte
   // Decoded result words.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte_0, [15:8] out_byte_1,
                                              // [23:16] out_byte_2, [31:24] out_byte_3,
                                              // [34:32] byte_count, [39:35] zero
   output logic                  rsp_tlast,   // run_last
   output logic                  rsp_tuser    // bad_distance
);

   localparam int AW = $clog2(HISTORY_DEPTH);

   // Control state.
   state_type                       state_ff, state_in;
   phase_type                       phase_ff, phase_in;
   logic [7:0]                      dist_ff, dist_in;
   logic [7:0]                      remain_ff, remain_in;
   logic [COUNT_W-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]                   ptr_ff, ptr_in;
   logic                            wrap_ff, wrap_in;

   // Lane staging for a match in progress.
   logic [OUT_LANES-1:0][7:0]       lane_ff, lane_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [OUT_LANES-1:0][7:0]       rsp_bytes_ff;
   logic [COUNT_W-1:0]              rsp_cnt_ff;
   logic                            rsp_last_ff;
   logic                            rsp_bad_ff;

   // Values loaded into the output register.
   logic                            load_out;
   logic [OUT_LANES-1:0][7:0]       ld_bytes;
   logic [COUNT_W-1:0]              ld_cnt;
   logic                            ld_last;
   logic                            ld_bad;

   // History memory ports.
   logic [7:0]                      hist_mem [HISTORY_DEPTH];
   logic                            mem_we;
   logic [7:0]                      mem_wdata;
   logic [AW-1:0]                   rd_addr;
   logic [7:0]                      rd_data_ff;
   logic                            rd_valid_ff;
   logic                            rd_direct;
   logic                            rd_hit;
   logic [AW:0]                     rd_sum;

   logic                            slot_free;
   logic                            req_fire;
   logic                            ptr_at_end;
   logic [AW-1:0]                   ptr_step;
   logic [7:0]                      copy_byte;

   // Handshake.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;

   // Write pointer advance with wrap at the history depth.
   assign ptr_at_end = (ptr_ff == AW'(HISTORY_DEPTH - 1));
   assign ptr_step   = ptr_at_end ? '0 : ptr_ff + 1'b1;

   // Source address distance bytes back; entries not yet written read as zero.
   assign rd_direct = (ptr_ff >= AW'(dist_ff));
   assign rd_sum    = {1'b0, ptr_ff} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(dist_ff);
   assign rd_addr   = rd_direct ? (ptr_ff - AW'(dist_ff)) : rd_sum[AW-1:0];
   assign rd_hit    = wrap_ff || rd_direct;
   assign copy_byte = rd_valid_ff ? rd_data_ff : 8'h00;

   // History memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[ptr_ff] <= mem_wdata;
      end
      rd_data_ff  <= hist_mem[rd_addr];
      rd_valid_ff <= rd_hit;
   end

   // Parser and copy sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      dist_in      = dist_ff;
      remain_in    = remain_ff;
      cnt_in       = cnt_ff;
      lane_in      = lane_ff;
      mem_we       = 1'b0;
      mem_wdata    = 8'h00;
      load_out     = 1'b0;
      ld_bytes     = '0;
      ld_cnt       = '0;
      ld_last      = 1'b0;
      ld_bad       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (phase_ff)
                  PH_MARKER: begin
                     phase_in = PH_LITERAL;
                     if (req_tdata == ESCAPE_BYTE) begin
                        mem_we      = 1'b1;
                        mem_wdata   = MARKER_BYTE;
                        load_out    = 1'b1;
                        ld_bytes[0] = MARKER_BYTE;
                        ld_cnt      = COUNT_W'(1);
                        ld_last     = 1'b1;
                     end else begin
                        dist_in  = req_tdata;
                        phase_in = PH_LENGTH;
                     end
                  end
                  PH_LENGTH: begin
                     phase_in = PH_LITERAL;
                     if (dist_ff == 8'h00) begin
                        load_out = 1'b1;
                        ld_last  = 1'b1;
                        ld_bad   = 1'b1;
                     end else if (req_tdata != 8'h00) begin
                        remain_in = req_tdata;
                        cnt_in    = '0;
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                     phase_in = PH_LITERAL;
                     if (req_tdata == MARKER_BYTE) begin
                        phase_in = PH_MARKER;
                     end else begin
                        mem_we      = 1'b1;
                        mem_wdata   = req_tdata;
                        load_out    = 1'b1;
                        ld_bytes[0] = req_tdata;
                        ld_cnt      = COUNT_W'(1);
                        ld_last     = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // Append the copied byte to the history and to the current lane.
            mem_we                = 1'b1;
            mem_wdata             = copy_byte;
            lane_in[cnt_ff[1:0]]  = copy_byte;
            cnt_in                = cnt_ff + 1'b1;
            remain_in             = remain_ff - 1'b1;
            if (cnt_ff == COUNT_W'(OUT_LANES - 1) || remain_ff == 8'd1) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               load_out = 1'b1;
               for (int i = 0; i < OUT_LANES; i++) begin
                  ld_bytes[i] = (COUNT_W'(i) < cnt_ff) ? lane_ff[i] : 8'h00;
               end
               ld_cnt   = cnt_ff;
               ld_last  = (remain_ff == 8'h00);
               cnt_in   = '0;
               state_in = (remain_ff == 8'h00) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pointer and fill tracking follow every history write.
   assign ptr_in  = mem_we ? ptr_step : ptr_ff;
   assign wrap_in = wrap_ff || (mem_we && ptr_at_end);

   // Output valid: set on a load, cleared once the word is taken.
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LITERAL;
         dist_ff      <= 8'h00;
         remain_ff    <= 8'h00;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         dist_ff      <= dist_in;
         remain_ff    <= remain_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      if (load_out) begin
         rsp_bytes_ff <= ld_bytes;
         rsp_cnt_ff   <= ld_cnt;
         rsp_last_ff  <= ld_last;
         rsp_bad_ff   <= ld_bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - COUNT_W - 8 * OUT_LANES)'(0), rsp_cnt_ff, rsp_bytes_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // An error word carries no bytes and closes its run.
   `LTD_ASSERT_IMPLIES(a_bad_word_empty, rsp_valid_ff && rsp_bad_ff, rsp_cnt_ff == '0 && rsp_last_ff, "bad distance word must be empty and last")
   // A short data word only ever ends a run.
   `LTD_ASSERT_IMPLIES(a_short_word_last, rsp_valid_ff && !rsp_bad_ff && rsp_cnt_ff != COUNT_W'(OUT_LANES), rsp_last_ff && rsp_cnt_ff != '0, "partial word must be the last of its run")
   // A flush never hands off an empty lane group.
   `LTD_ASSERT_IMPLIES(a_flush_nonempty, state_ff == ST_FLUSH, cnt_ff != '0 && cnt_ff <= COUNT_W'(OUT_LANES), "flush with no staged bytes")
   // The write pointer stays inside the history.
   `LTD_ASSERT_HOLDS(a_ptr_in_range, ptr_ff <= AW'(HISTORY_DEPTH - 1), "history pointer out of range")

endmodule
